/* src/column_predicate_scan_bitvector_assert.svh */
// Assertion macros used by the top-level RTL
`ifndef COLUMN_PREDICATE_SCAN_BITVECTOR_ASSERT_SVH
`define COLUMN_PREDICATE_SCAN_BITVECTOR_ASSERT_SVH

// same-cycle implication
`define CPSB_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define CPSB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* src/cpsb_pkg.sv */
package cpsb_pkg;

  localparam int CODE_BITS      = 32;
  localparam int WORD_BITS      = 64;
  localparam int POS_BITS       = $clog2(WORD_BITS);
  localparam int INDEX_BITS     = 10;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [2:0] {
    CMP_EQ    = 3'd0,
    CMP_NE    = 3'd1,
    CMP_GT    = 3'd2,
    CMP_LT    = 3'd3,
    CMP_GE    = 3'd4,
    CMP_LE    = 3'd5,
    CMP_RANGE = 3'd6
  } cmp_op_t;

  typedef enum logic [1:0] {
    COMB_SET = 2'd0,
    COMB_AND = 2'd1,
    COMB_OR  = 2'd2
  } comb_op_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARATOR   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPERAND_LOW  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPERAND_HIGH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMBINE_OP   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE       = 3'd4;

  typedef struct packed {
    cmp_op_t                comparator;
    logic [CODE_BITS-1:0]   operand_low;
    logic [CODE_BITS-1:0]   operand_high;
    comb_op_t               combine_op;
    logic                   compare_source;
  } cfg_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]   column_code;
    logic [CODE_BITS-1:0]   paired_code;
    logic [WORD_BITS-1:0]   prior_word;
    logic                   last_code;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   result_word;
    logic [INDEX_BITS-1:0]  word_index;
    logic                   final_word;
  } result_t;

  typedef struct packed {
    logic                   emit;
    logic [POS_BITS-1:0]    bit_pos;
    logic [INDEX_BITS-1:0]  word_cnt;
  } pack_st_t;

endpackage

/* src/cpsb_ifs.sv */
interface cpsb_in_if;
  import cpsb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] column_code;
  logic [CODE_BITS-1:0] paired_code;
  logic [WORD_BITS-1:0] prior_word;
  logic                 last_code;
  modport source (output valid, column_code, paired_code, prior_word, last_code,
                  input ready);
  modport sink   (input valid, column_code, paired_code, prior_word, last_code,
                  output ready);
endinterface

interface cpsb_out_if;
  import cpsb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WORD_BITS-1:0]  result_word;
  logic [INDEX_BITS-1:0] word_index;
  logic                  final_word;
  modport source (output valid, result_word, word_index, final_word, input ready);
  modport sink   (input valid, result_word, word_index, final_word, output ready);
endinterface

interface cpsb_cfg_if;
  import cpsb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/cpsb_in_stage.sv */
module cpsb_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  cpsb_pkg::item_t in_item,
  output logic            in_ready,
  input  logic            take,
  output logic            s1_valid,
  output cpsb_pkg::item_t s1_item
);
  import cpsb_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* src/cpsb_match.sv */
module cpsb_match (
  input  cpsb_pkg::cfg_t                  cfg,
  input  logic [cpsb_pkg::CODE_BITS-1:0]  column_code,
  input  logic [cpsb_pkg::CODE_BITS-1:0]  paired_code,
  output logic                            hit
);
  import cpsb_pkg::*;

  logic [CODE_BITS-1:0] rhs;

  assign rhs = cfg.compare_source ? paired_code : cfg.operand_low;

  always_comb begin
    unique case (cfg.comparator)
      CMP_EQ:    hit = (column_code == rhs);
      CMP_NE:    hit = (column_code != rhs);
      CMP_GT:    hit = (column_code >  rhs);
      CMP_LT:    hit = (column_code <  rhs);
      CMP_GE:    hit = (column_code >= rhs);
      CMP_LE:    hit = (column_code <= rhs);
      CMP_RANGE: hit = (column_code >= cfg.operand_low) &&
                       (column_code <= cfg.operand_high);
      default:   hit = 1'b0;
    endcase
  end

endmodule

/* src/cpsb_pack.sv */
module cpsb_pack (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic                            hit,
  input  logic                            last,
  input  logic [cpsb_pkg::WORD_BITS-1:0]  prior_word,
  input  cpsb_pkg::comb_op_t              combine_op,
  output logic                            can_take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cpsb_pkg::result_t               result,
  output cpsb_pkg::pack_st_t              status
);
  import cpsb_pkg::*;

  logic [WORD_BITS-1:0]  acc_r, acc_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r;

  logic [WORD_BITS-1:0]  pos_mask;
  logic [WORD_BITS-1:0]  acc_hit;
  logic [POS_BITS:0]     fill;
  logic [WORD_BITS-1:0]  valid_mask;
  logic [WORD_BITS-1:0]  combined;
  logic                  emit;

  assign can_take   = !out_valid_r || out_ready;
  assign pos_mask   = {1'b1, {(WORD_BITS-1){1'b0}}} >> pos_r;
  assign acc_hit    = hit ? (acc_r | pos_mask) : acc_r;
  assign fill       = {1'b0, pos_r} + (POS_BITS+1)'(1);
  assign valid_mask = ~({WORD_BITS{1'b1}} >> fill);
  assign emit       = take && ((pos_r == POS_BITS'(WORD_BITS-1)) || last);

  always_comb begin
    case (combine_op)
      COMB_AND: combined = acc_hit & prior_word;
      COMB_OR:  combined = acc_hit | prior_word;
      default:  combined = acc_hit;
    endcase
  end

  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      if (emit) begin
        acc_nxt       = '0;
        pos_nxt       = '0;
        cnt_nxt       = last ? '0 : cnt_r + INDEX_BITS'(1);
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = acc_hit;
        pos_nxt = pos_r + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.result_word <= combined & valid_mask;
      res_r.word_index  <= cnt_r;
      res_r.final_word  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign result          = res_r;
  assign status.emit     = emit;
  assign status.bit_pos  = pos_r;
  assign status.word_cnt = cnt_r;

endmodule

/* src/column_predicate_scan_bitvector.sv */
// channel   dir  request contents
// in_chan   in   column_code, paired_code, prior_word, last_code
// out_chan  out  result_word, word_index, final_word
// cfg_chan  in   index, data (register write, always ready)
//
// One request per cycle sustained unless the output stalls; a word becomes valid
// on the output once the request that closes it has passed the input register, then
// compare/pack into the output register. A word leaves every 64 codes, or at last_code.
// Reset clears config registers, bit position, word counter and valid flags.
// Output stall backs up into the input register; input ready drops in the same cycle.
`include "column_predicate_scan_bitvector_assert.svh"

module column_predicate_scan_bitvector (
  input  logic       clk,
  input  logic       rst_n,
  cpsb_in_if.sink    in_chan,
  cpsb_out_if.source out_chan,
  cpsb_cfg_if.sink   cfg_chan
);
  import cpsb_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  item_t    in_item;
  item_t    s1_item;
  logic     s1_valid;
  logic     s1_take;
  logic     can_take;
  logic     hit;
  result_t  result;
  pack_st_t pack_st;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_COMPARATOR:   cfg_nxt.comparator     = cmp_op_t'(cfg_chan.data[2:0]);
        REG_OPERAND_LOW:  cfg_nxt.operand_low    = cfg_chan.data[CODE_BITS-1:0];
        REG_OPERAND_HIGH: cfg_nxt.operand_high   = cfg_chan.data[CODE_BITS-1:0];
        REG_COMBINE_OP:   cfg_nxt.combine_op     = comb_op_t'(cfg_chan.data[1:0]);
        REG_SOURCE:       cfg_nxt.compare_source = cfg_chan.data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{comparator: CMP_EQ, operand_low: '0, operand_high: '0,
                 combine_op: COMB_SET, compare_source: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.column_code = in_chan.column_code;
  assign in_item.paired_code = in_chan.paired_code;
  assign in_item.prior_word  = in_chan.prior_word;
  assign in_item.last_code   = in_chan.last_code;

  assign s1_take = s1_valid && can_take;

  cpsb_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_item  (in_item),
    .in_ready (in_chan.ready),
    .take     (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cpsb_match u_match (
    .cfg         (cfg_r),
    .column_code (s1_item.column_code),
    .paired_code (s1_item.paired_code),
    .hit         (hit)
  );

  cpsb_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (s1_take),
    .hit        (hit),
    .last       (s1_item.last_code),
    .prior_word (s1_item.prior_word),
    .combine_op (cfg_r.combine_op),
    .can_take   (can_take),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .result     (result),
    .status     (pack_st)
  );

  assign out_chan.result_word = result.result_word;
  assign out_chan.word_index  = result.word_index;
  assign out_chan.final_word  = result.final_word;

  `CPSB_ASSERT_NEXT(a_last_restarts, clk, rst_n, s1_take && s1_item.last_code, (pack_st.bit_pos == '0) && (pack_st.word_cnt == '0), "stream end did not restart position and counter")
  `CPSB_ASSERT_NEXT(a_pos_advances, clk, rst_n, s1_take && !pack_st.emit, pack_st.bit_pos == POS_BITS'($past(pack_st.bit_pos) + 1'b1), "bit position did not advance")
  `CPSB_ASSERT_IMPL(a_ready_hold, clk, rst_n, !in_chan.ready, s1_valid && !can_take, "input stalled without a blocked request")
  `CPSB_ASSERT_NEXT(a_emit_valid, clk, rst_n, pack_st.emit, out_chan.valid, "emitted word not presented")

endmodule

/* sim/tb_column_predicate_scan_bitvector.sv */
`timescale 1ns / 100ps

import cpsb_pkg::*;

class match_word_board;
  logic [2:0]           cmp_sel    = '0;
  logic [CODE_BITS-1:0] op_low     = '0;
  logic [CODE_BITS-1:0] op_high    = '0;
  logic [1:0]           comb_sel   = '0;
  logic                 use_paired = 1'b0;

  logic [WORD_BITS-1:0]  match_bits = '0;
  int unsigned           fill       = 0;
  logic [INDEX_BITS-1:0] word_count = '0;

  result_t     pending_words[$];
  int unsigned failures = 0;
  int unsigned reported = 0;

  function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_COMPARATOR:   cmp_sel = data[2:0];
      REG_OPERAND_LOW:  op_low = data[CODE_BITS-1:0];
      REG_OPERAND_HIGH: op_high = data[CODE_BITS-1:0];
      REG_COMBINE_OP:   comb_sel = data[1:0];
      REG_SOURCE:       use_paired = data[0];
      default: ;
    endcase
  endfunction

  function void note_request(item_t it);
    logic [CODE_BITS-1:0] rhs;
    logic                 hit;
    logic [WORD_BITS-1:0] word;
    result_t              w;
    rhs = use_paired ? it.paired_code : op_low;
    case (cmp_sel)
      CMP_EQ:    hit = (it.column_code == rhs);
      CMP_NE:    hit = (it.column_code != rhs);
      CMP_GT:    hit = (it.column_code > rhs);
      CMP_LT:    hit = (it.column_code < rhs);
      CMP_GE:    hit = (it.column_code >= rhs);
      CMP_LE:    hit = (it.column_code <= rhs);
      CMP_RANGE: hit = (it.column_code >= op_low) && (it.column_code <= op_high);
      default:   hit = 1'b0;
    endcase
    if (hit) match_bits[WORD_BITS-1-fill] = 1'b1;
    fill++;
    if (fill < WORD_BITS && !it.last_code) return;
    word = match_bits;
    case (comb_sel)
      COMB_AND: word &= it.prior_word;
      COMB_OR:  word |= it.prior_word;
      default: ;
    endcase
    // rows past the end of a partial word stay clear
    word &= ~{WORD_BITS{1'b0}} << (WORD_BITS - fill);
    w.result_word = word;
    w.word_index  = word_count;
    w.final_word  = it.last_code;
    pending_words.push_back(w);
    match_bits = '0;
    fill       = 0;
    word_count = it.last_code ? '0 : word_count + 1'b1;
  endfunction

  function void check_word(result_t got);
    result_t want;
    if (pending_words.size() == 0) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("unexpected word %h index %0d last %0b",
                 got.result_word, got.word_index, got.final_word);
      end
      return;
    end
    want = pending_words.pop_front();
    if (got !== want) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("mismatch: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                 want.result_word, want.word_index, want.final_word,
                 got.result_word, got.word_index, got.final_word);
      end
    end
  endfunction
endclass

module tb_column_predicate_scan_bitvector;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

  logic clk;
  logic rst_n;

  cpsb_in_if  in_chan();
  cpsb_out_if out_chan();
  cpsb_cfg_if cfg_chan();

  column_predicate_scan_bitvector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  match_word_board board = new();

  int      idle_pct  = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  result_t got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready) begin
        got.result_word = out_chan.result_word;
        got.word_index  = out_chan.word_index;
        got.final_word  = out_chan.final_word;
        board.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // noisy adds random upper data bits to the narrow registers
  task automatic set_config(logic [2:0] cmp, logic [31:0] lo, logic [31:0] hi,
                            logic [1:0] comb, logic src, bit noisy);
    logic [31:0] junk;
    junk = noisy ? $urandom : 32'd0;
    write_reg(REG_COMPARATOR, {junk[31:3], cmp});
    write_reg(REG_OPERAND_LOW, lo);
    write_reg(REG_OPERAND_HIGH, hi);
    write_reg(REG_COMBINE_OP, {junk[31:2], comb});
    write_reg(REG_SOURCE, {junk[31:1], src});
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.column_code <= it.column_code;
    in_chan.paired_code <= it.paired_code;
    in_chan.prior_word  <= it.prior_word;
    in_chan.last_code   <= it.last_code;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_request(it);
  endtask

  // pipeline may still hold requests that produce no word
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CODE_BITS-1:0] pick_code();
    case ($urandom_range(7))
      0:       return board.op_low;
      1:       return board.op_high;
      2:       return board.op_low + 1'b1;
      3:       return board.op_low - 1'b1;
      4:       return '0;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_stream(int unsigned len, bit close);
    item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.column_code = pick_code();
      case ($urandom_range(3))
        0:       it.paired_code = it.column_code;
        1:       it.paired_code = it.column_code + 1'b1;
        2:       it.paired_code = it.column_code - 1'b1;
        default: it.paired_code = $urandom;
      endcase
      it.prior_word = {$urandom, $urandom};
      it.last_code  = close && (i == len - 1);
      send_item(it);
    end
  endtask

  task automatic random_config(logic [2:0] cmp);
    set_config(cmp, pick_operand(), pick_operand(), 2'($urandom_range(3)),
               1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    item_t       it;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        src;
    int unsigned sent;
    int unsigned len;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.column_code <= '0;
    in_chan.paired_code <= '0;
    in_chan.prior_word  <= '0;
    in_chan.last_code   <= 1'b0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= '0;
    cfg_chan.data       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // one short stream per comparator code, including unused code 7, combine mode cycling
    for (int k = 0; k < 8; k++) begin
      settle();
      lo  = (k < 4) ? 32'h8000_0000 : 32'hFFFF_FFFF;
      hi  = 32'h0000_0000;
      src = k[0];
      if (k == CMP_RANGE) begin
        // empty range, paired source ignored
        lo  = 32'd5;
        hi  = 32'd3;
        src = 1'b1;
      end
      set_config(k[2:0], lo, hi, k[1:0], src, 1'b0);
      it = '{column_code: '0, paired_code: '1, prior_word: '1, last_code: 1'b0};
      send_item(it);
      it = '{column_code: '1, paired_code: '0, prior_word: '0, last_code: 1'b0};
      send_item(it);
      it = '{column_code: lo, paired_code: lo, prior_word: {$urandom, $urandom},
             last_code: 1'b1};
      send_item(it);
    end

    settle();
    set_config(CMP_RANGE, 32'd0, 32'hFFFF_FFFF, COMB_OR, 1'b0, 1'b0);
    write_reg(REG_SPARE, $urandom);
    cfg_chan.valid <= 1'b0;
    it = '{column_code: 32'h1234_5678, paired_code: '0, prior_word: '1, last_code: 1'b1};
    send_item(it);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      random_config(ph[2:0]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      sent = 0;
      while (sent < 120) begin
        case ($urandom_range(7))
          0:       len = 1;
          1:       len = $urandom_range(2, 8);
          2:       len = 63;
          3:       len = 64;
          4:       len = 65;
          5:       len = 128;
          default: len = $urandom_range(1, 150);
        endcase
        send_stream(len, $urandom_range(7) != 0);
        sent += len;
      end
    end

    // receiver holds off while short streams keep coming
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    random_config(3'($urandom_range(7)));
    hold_left = 300;
    for (int s = 0; s < 40; s++) send_stream(3, 1'b1);

    // long stream spanning several words
    settle();
    random_config(3'($urandom_range(7)));
    send_stream(3 * WORD_BITS + 5, 1'b1);

    in_chan.valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.pending_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/cpsb_pkg.sv
src/cpsb_ifs.sv
src/cpsb_in_stage.sv
src/cpsb_match.sv
src/cpsb_pack.sv
src/column_predicate_scan_bitvector.sv
sim/tb_column_predicate_scan_bitvector.sv
